@@ design/bsce_pkg.sv @@
// ----------------------------------------------------------------------------
// B-spline evaluator package
// Shared constants, function codes and divider request/response types.
// ----------------------------------------------------------------------------
`default_nettype none

package bsce_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DEGREE_DEF = 5;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    localparam logic [1:0] FUNC_POINT = 2'd0;
    localparam logic [1:0] FUNC_KNOT  = 2'd1;
    localparam logic [1:0] FUNC_EVAL  = 2'd2;

    localparam logic REG_DEGREE = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    localparam logic [2:0] DEGREE_RST = 3'd3;
    localparam logic [6:0] COUNT_RST  = 7'd4;

    typedef struct packed {
        logic               start;
        logic signed [32:0] num;
        logic signed [16:0] den;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [32:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ design/bsce_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/bsce_div.sv @@
// ----------------------------------------------------------------------------
// Bit-serial divider
// Signed division truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsce_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bsce_pkg::t_div_req i_req,
    output bsce_pkg::t_div_rsp     o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic [16:0] r_rem;
    logic [31:0] r_qn;
    logic [15:0] r_dmag;

    logic [32:0] nmag;
    logic [16:0] dmag;
    logic [16:0] sh;
    logic        fit;

    assign nmag = i_req.num[32] ? 33'(-i_req.num) : 33'(i_req.num);
    assign dmag = i_req.den[16] ? 17'(-i_req.den) : 17'(i_req.den);
    assign sh   = {r_rem[15:0], r_qn[31]};
    assign fit  = sh >= {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_qn   <= nmag[31:0];
                r_dmag <= dmag[15:0];
                r_neg  <= i_req.num[32] ^ i_req.den[16];
            end else if (r_busy) begin
                r_rem <= fit ? 17'(sh - {1'b0, r_dmag}) : sh;
                r_qn  <= {r_qn[30:0], fit};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -$signed({1'b0, r_qn}) : $signed({1'b0, r_qn});

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 5'd31) |=> r_done)
        else $error("divider missed done");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.start && !r_busy) |=> (r_busy && r_cnt == 5'd0))
        else $error("divider failed to start");

endmodule

`default_nettype wire

@@ design/bsce_eval.sv @@
// ----------------------------------------------------------------------------
// B-spline query sequencer
// Walks the Cox-de Boor triangle per basis index with one shared multiplier
// and the serial divider, then accumulates basis times control point.
// ----------------------------------------------------------------------------
`default_nettype none

module bsce_eval #(
    parameter int MAX_POINTS = bsce_pkg::MAX_POINTS_DEF,
    parameter int MAX_DEGREE = bsce_pkg::MAX_DEGREE_DEF,
    parameter int KAW        = 7,
    parameter int CAW        = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [15:0]        i_param,
    input  wire logic [2:0]         i_degree,
    input  wire logic [6:0]         i_count,
    input  wire logic               i_out_free,
    output logic      [KAW-1:0]     o_kaddr,
    input  wire logic [15:0]        i_kdata,
    output logic      [CAW-1:0]     o_caddr,
    input  wire logic [31:0]        i_cdata,
    output bsce_pkg::t_div_req      o_div,
    input  wire bsce_pkg::t_div_rsp i_div,
    output logic                    o_idle,
    output logic                    o_done,
    output logic      [31:0]        o_value,
    output logic                    o_sat
);

    localparam int L  = MAX_DEGREE + 1;
    localparam int IW = $clog2(MAX_POINTS + 1);
    localparam int SW = 50 + IW + 1;
    localparam int RW = $clog2(L + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LAST  = 5'd1;
    localparam logic [4:0] S_LASTC = 5'd2;
    localparam logic [4:0] S_ZA    = 5'd3;
    localparam logic [4:0] S_ZB    = 5'd4;
    localparam logic [4:0] S_ZC    = 5'd5;
    localparam logic [4:0] S_ROT   = 5'd6;
    localparam logic [4:0] S_RA    = 5'd7;
    localparam logic [4:0] S_RB    = 5'd8;
    localparam logic [4:0] S_RC    = 5'd9;
    localparam logic [4:0] S_RD    = 5'd10;
    localparam logic [4:0] S_RE    = 5'd11;
    localparam logic [4:0] S_ML    = 5'd12;
    localparam logic [4:0] S_DLS   = 5'd13;
    localparam logic [4:0] S_DLW   = 5'd14;
    localparam logic [4:0] S_MR    = 5'd15;
    localparam logic [4:0] S_DRS   = 5'd16;
    localparam logic [4:0] S_DRW   = 5'd17;
    localparam logic [4:0] S_SUM   = 5'd18;
    localparam logic [4:0] S_CA    = 5'd19;
    localparam logic [4:0] S_CB    = 5'd20;
    localparam logic [4:0] S_CC    = 5'd21;
    localparam logic [4:0] S_OUT   = 5'd22;

    logic [4:0]           r_state;
    logic [15:0]          r_t;
    logic [2:0]           r_deg;
    logic [IW-1:0]        r_cnt;
    logic [IW-1:0]        r_i;
    logic [2:0]           r_j;
    logic [2:0]           r_q;
    logic [RW-1:0]        r_rot;
    logic [15:0]          r_last;
    logic [15:0]          r_ka;
    logic [15:0]          r_kq;
    logic [15:0]          r_k1;
    logic [15:0]          r_kq1;
    logic [15:0]          r_ring [L];
    logic signed [49:0]   r_prod;
    logic signed [33:0]   r_acc;
    logic signed [SW-1:0] r_sum;

    logic [2:0]           deg_c;
    logic [IW-1:0]        cnt_c;
    logic [31:0]          ij;
    logic [31:0]          n_w;
    logic [31:0]          ka_w;
    logic signed [17:0]   mul_a;
    logic signed [31:0]   mul_b;
    logic signed [49:0]   prod;
    logic                 on;
    logic [15:0]          clamp;
    logic signed [16:0]   ld;
    logic signed [16:0]   rd;
    logic signed [SW-1:0] rnd;
    logic signed [SW-1:0] qv;

    assign deg_c = (32'(i_degree) > MAX_DEGREE) ? 3'(MAX_DEGREE) : i_degree;
    assign cnt_c = (32'(i_count) > MAX_POINTS) ? IW'(MAX_POINTS) : IW'(i_count);
    assign ij    = 32'(r_i) + 32'(r_j);
    assign n_w   = 32'(r_cnt) - 32'd1;

    always_comb begin
        unique case (r_state)
            S_LAST:  ka_w = n_w + 32'(r_deg) + 32'd1;
            S_ZA:    ka_w = ij;
            S_ZB:    ka_w = ij + 32'd1;
            S_RA:    ka_w = ij;
            S_RB:    ka_w = ij + 32'(r_q);
            S_RC:    ka_w = ij + 32'd1;
            S_RD:    ka_w = ij + 32'(r_q) + 32'd1;
            default: ka_w = '0;
        endcase
    end
    assign o_kaddr = ka_w[KAW-1:0];
    assign o_caddr = CAW'(r_i);

    always_comb begin
        unique case (r_state)
            S_ML: begin
                mul_a = $signed({2'b00, r_t}) - $signed({2'b00, r_ka});
                mul_b = $signed({16'h0000, r_ring[0]});
            end
            S_MR: begin
                mul_a = $signed({2'b00, r_kq1}) - $signed({2'b00, r_t});
                mul_b = $signed({16'h0000, r_ring[1]});
            end
            default: begin
                mul_a = $signed({2'b00, r_ring[0]});
                mul_b = $signed(i_cdata);
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    assign on = ((r_t >= r_ka) && (r_t < i_kdata)) || ((ij == n_w) && (r_t == r_last));
    assign ld = $signed({1'b0, r_kq}) - $signed({1'b0, r_ka});
    assign rd = $signed({1'b0, r_kq1}) - $signed({1'b0, r_k1});

    always_comb begin
        if (r_acc[33]) begin
            clamp = '0;
        end else if (r_acc > 34'sd32768) begin
            clamp = bsce_pkg::ONE_Q15;
        end else begin
            clamp = r_acc[15:0];
        end
    end

    always_comb begin
        o_div.start = 1'b0;
        o_div.num   = r_prod[32:0];
        o_div.den   = ld;
        if (r_state == S_DLS) begin
            o_div.start = (ld != 17'sd0);
        end else if (r_state == S_DRS) begin
            o_div.start = (rd != 17'sd0);
            o_div.den   = rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_q     <= '0;
            r_rot   <= '0;
            for (int k = 0; k < L; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_t   <= i_param;
                        r_deg <= deg_c;
                        r_cnt <= cnt_c;
                        r_i   <= '0;
                        r_j   <= '0;
                        r_q   <= '0;
                        r_sum <= '0;
                        r_state <= (cnt_c == '0) ? S_OUT : S_LAST;
                    end
                end
                S_LAST:  r_state <= S_LASTC;
                S_LASTC: begin
                    r_last  <= i_kdata;
                    r_state <= S_ZA;
                end
                S_ZA: r_state <= S_ZB;
                S_ZB: begin
                    r_ka    <= i_kdata;
                    r_state <= S_ZC;
                end
                S_ZC: begin
                    for (int k = 0; k < L - 1; k++) begin
                        r_ring[k] <= r_ring[k+1];
                    end
                    r_ring[L-1] <= on ? bsce_pkg::ONE_Q15 : 16'h0000;
                    if (r_j == r_deg) begin
                        r_rot   <= RW'(L - 1 - 32'(r_deg));
                        r_state <= S_ROT;
                    end else begin
                        r_j     <= r_j + 3'd1;
                        r_state <= S_ZA;
                    end
                end
                S_ROT: begin
                    if (r_rot == '0) begin
                        r_j <= '0;
                        if (r_q == r_deg) begin
                            r_state <= S_CA;
                        end else begin
                            r_q     <= r_q + 3'd1;
                            r_state <= S_RA;
                        end
                    end else begin
                        for (int k = 0; k < L - 1; k++) begin
                            r_ring[k] <= r_ring[k+1];
                        end
                        r_ring[L-1] <= r_ring[0];
                        r_rot <= r_rot - RW'(1);
                    end
                end
                S_RA: r_state <= S_RB;
                S_RB: begin
                    r_ka    <= i_kdata;
                    r_state <= S_RC;
                end
                S_RC: begin
                    r_kq    <= i_kdata;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_k1    <= i_kdata;
                    r_state <= S_RE;
                end
                S_RE: begin
                    r_kq1   <= i_kdata;
                    r_state <= S_ML;
                end
                S_ML: begin
                    r_prod  <= prod;
                    r_acc   <= '0;
                    r_state <= S_DLS;
                end
                S_DLS: r_state <= (ld != 17'sd0) ? S_DLW : S_MR;
                S_DLW: begin
                    if (i_div.done) begin
                        r_acc   <= r_acc + 34'(i_div.quo);
                        r_state <= S_MR;
                    end
                end
                S_MR: begin
                    r_prod  <= prod;
                    r_state <= S_DRS;
                end
                S_DRS: r_state <= (rd != 17'sd0) ? S_DRW : S_SUM;
                S_DRW: begin
                    if (i_div.done) begin
                        r_acc   <= r_acc + 34'(i_div.quo);
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    for (int k = 0; k < L - 1; k++) begin
                        r_ring[k] <= r_ring[k+1];
                    end
                    r_ring[L-1] <= clamp;
                    if (r_j == r_deg - r_q) begin
                        r_rot   <= RW'(L - 1 - 32'(r_deg) + 32'(r_q));
                        r_state <= S_ROT;
                    end else begin
                        r_j     <= r_j + 3'd1;
                        r_state <= S_RA;
                    end
                end
                S_CA: r_state <= S_CB;
                S_CB: begin
                    r_prod  <= prod;
                    r_state <= S_CC;
                end
                S_CC: begin
                    r_sum <= r_sum + SW'(r_prod);
                    r_j   <= '0;
                    r_q   <= '0;
                    if (32'(r_i) + 32'd1 == 32'(r_cnt)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= S_ZA;
                    end
                end
                S_OUT: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // round half up, then clip to 32 bits
    assign rnd    = r_sum + SW'(16384);
    assign qv     = rnd >>> 15;
    assign o_sat  = !((&qv[SW-1:31]) || !(|qv[SW-1:31]));
    assign o_value = o_sat ? (qv[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff) : qv[31:0];
    assign o_done = (r_state == S_OUT) && i_out_free;
    assign o_idle = (r_state == S_IDLE);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("query request while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div.start |-> (!i_div.busy && o_div.den != 17'sd0))
        else $error("bad divider request");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |=> (r_ring[L-1] <= bsce_pkg::ONE_Q15))
        else $error("basis value out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DLW || r_state == S_DRW) |-> i_div.busy || i_div.done)
        else $error("waiting on idle divider");

endmodule

`default_nettype wire

@@ design/bspline_curve_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// B-spline curve evaluator core
// Control point and knot stores, APB registers and stream ports around the
// Cox-de Boor query sequencer.
// ----------------------------------------------------------------------------
// Control point and knot writes are accepted back to back. A query's result
// can wait on the output until taken. Every basis raise runs up to two passes
// of the single bit-serial divider, one per nonzero knot difference; each zero
// knot difference skips its pass. The multiplier and knot RAM port are shared
// by all steps. The input is not ready while a query runs.
// Stores hold garbage until written. paddr bit 2 selects the register:
// 0 degree, 4 point count.
`default_nettype none

module bspline_curve_evaluator_core #(
    parameter int MAX_POINTS = bsce_pkg::MAX_POINTS_DEF,
    parameter int MAX_DEGREE = bsce_pkg::MAX_DEGREE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,  // slot[6:0], write_value[38:7], param[54:39]
    input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // curve_value[31:0]
    output logic      [0:0]  m_axis_tuser,  // saturated[0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int KD  = MAX_POINTS + MAX_DEGREE + 1;
    localparam int KAW = $clog2(KD);
    localparam int CAW = $clog2(MAX_POINTS);

    logic [2:0]  r_degree;
    logic [6:0]  r_count;
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic        r_osat;

    logic [1:0]  func;
    logic [6:0]  slot;
    logic [31:0] wval;
    logic [15:0] param;
    logic [31:0] slot_w;
    logic        accept;
    logic        idle;
    logic        done;
    logic [31:0] value;
    logic        sat;
    logic        out_free;
    logic [KAW-1:0] kaddr;
    logic [15:0]    kdata;
    logic [CAW-1:0] caddr;
    logic [31:0]    cdata;
    bsce_pkg::t_div_req div_req;
    bsce_pkg::t_div_rsp div_rsp;

    assign func   = s_axis_tuser;
    assign slot   = s_axis_tdata[6:0];
    assign wval   = s_axis_tdata[38:7];
    assign param  = s_axis_tdata[54:39];
    assign slot_w = 32'(slot);

    assign s_axis_tready = idle;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= bsce_pkg::DEGREE_RST;
            r_count  <= bsce_pkg::COUNT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                bsce_pkg::REG_DEGREE: r_degree <= pwdata[2:0];
                bsce_pkg::REG_COUNT:  r_count  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            bsce_pkg::REG_DEGREE: prdata = {29'd0, r_degree};
            bsce_pkg::REG_COUNT:  prdata = {25'd0, r_count};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_odata <= value;
            r_osat  <= sat;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osat;

    bsce_ram #(.WIDTH(32), .DEPTH(MAX_POINTS), .AW(CAW)) u_points (
        .i_clk   (i_clk),
        .i_we    (accept && func == bsce_pkg::FUNC_POINT && slot_w < MAX_POINTS),
        .i_waddr (slot_w[CAW-1:0]),
        .i_wdata (wval),
        .i_raddr (caddr),
        .o_rdata (cdata)
    );

    bsce_ram #(.WIDTH(16), .DEPTH(KD), .AW(KAW)) u_knots (
        .i_clk   (i_clk),
        .i_we    (accept && func == bsce_pkg::FUNC_KNOT && slot_w < KD),
        .i_waddr (slot_w[KAW-1:0]),
        .i_wdata (wval[15:0]),
        .i_raddr (kaddr),
        .o_rdata (kdata)
    );

    bsce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    bsce_eval #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DEGREE (MAX_DEGREE),
        .KAW        (KAW),
        .CAW        (CAW)
    ) u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && func == bsce_pkg::FUNC_EVAL),
        .i_param    (param),
        .i_degree   (r_degree),
        .i_count    (r_count),
        .i_out_free (out_free),
        .o_kaddr    (kaddr),
        .i_kdata    (kdata),
        .o_caddr    (caddr),
        .i_cdata    (cdata),
        .o_div      (div_req),
        .i_div      (div_rsp),
        .o_idle     (idle),
        .o_done     (done),
        .o_value    (value),
        .o_sat      (sat)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> out_free)
        else $error("result would overwrite pending output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && func == bsce_pkg::FUNC_EVAL) |=> !s_axis_tready)
        else $error("ready during query");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && func != bsce_pkg::FUNC_EVAL) |=> s_axis_tready)
        else $error("write request stalled the input");

endmodule

`default_nettype wire

@@ dv/bspline_curve_evaluator_core_tb.sv @@
// ----------------------------------------------------------------------------
// B-spline curve evaluator core testbench
// Loads control points and knot vectors, queries the curve over several
// degree and point-count settings and checks each curve value and saturation
// flag against a Cox-de Boor fixed-point predictor held in this bench.
// ----------------------------------------------------------------------------
`default_nettype none

module bspline_curve_evaluator_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS        = 64;
    localparam int NDEG        = 5;
    localparam int KDEPTH      = NPTS + NDEG + 1;
    localparam int ITEM_TARGET = 1850;
    localparam int CYCLE_LIMIT = 250000000;

    typedef struct {
        logic [1:0]  func;
        logic [6:0]  slot;
        logic [31:0] wval;
        logic [15:0] param;
    } t_spline_req;

    typedef struct {
        logic [31:0] value;
        logic        sat;
    } t_curve_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;  // slot[6:0], write_value[38:7], param[54:39]
    logic [1:0]  s_axis_tuser;  // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;  // curve_value[31:0]
    logic [0:0]  m_axis_tuser;  // saturated[0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bspline_curve_evaluator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    logic [2:0]         cur_degree = bsce_pkg::DEGREE_RST;
    logic [6:0]         cur_count  = bsce_pkg::COUNT_RST;
    logic signed [31:0] ctl_pts [NPTS];
    logic [15:0]        knots [KDEPTH];

    t_spline_req pending [$];
    t_curve_res  expected [$];

    int  items_sent;
    int  n_queries;
    int  n_writes;
    int  n_sat;
    int  n_checked;
    int  mismatches;
    int  cycles;
    bit  in_taken;
    int  in_gap;
    int  out_stall;
    bit  no_idle;

    function automatic longint knot_val(int k);
        return (k < KDEPTH) ? longint'(knots[k]) : 64'sd0;
    endfunction

    function automatic logic [15:0] raise_weight(int i, int q, longint t,
                                                 logic [15:0] lo, logic [15:0] hi);
        longint acc, ld, rd;
        acc = 0;
        ld  = knot_val(i + q) - knot_val(i);
        rd  = knot_val(i + q + 1) - knot_val(i + 1);
        if (ld != 0) acc += ((t - knot_val(i)) * longint'(lo)) / ld;
        if (rd != 0) acc += ((knot_val(i + q + 1) - t) * longint'(hi)) / rd;
        if (acc < 0) acc = 0;
        if (acc > 32768) acc = 32768;
        return acc[15:0];
    endfunction

    function automatic logic [15:0] basis_weight(int i, int deg, int n, longint t);
        logic [15:0] w [NDEG + 1];
        longint      last;
        int          k;
        last = knot_val(n + deg + 1);
        for (int j = 0; j <= deg; j++) begin
            k = i + j;
            w[j] = ((t >= knot_val(k) && t < knot_val(k + 1)) || (k == n && t == last))
                   ? bsce_pkg::ONE_Q15 : 16'd0;
        end
        for (int q = 1; q <= deg; q++)
            for (int j = 0; j + q <= deg; j++)
                w[j] = raise_weight(i + j, q, t, w[j], w[j + 1]);
        return w[0];
    endfunction

    function automatic t_curve_res curve_at(logic [15:0] param);
        t_curve_res r;
        int         deg, cnt;
        longint     acc, v, q;
        deg = (cur_degree > NDEG) ? NDEG : int'(cur_degree);
        cnt = (cur_count > NPTS) ? NPTS : int'(cur_count);
        acc = 0;
        for (int i = 0; i < cnt; i++)
            acc += longint'(basis_weight(i, deg, cnt - 1, longint'(param))) *
                   longint'(ctl_pts[i]);
        v = acc + 16384;
        q = (v >= 0) ? v / 32768 : -((-v + 32767) / 32768);
        r.sat = 1'b0;
        if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
            r.sat = 1'b1;
        end else if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
            r.sat = 1'b1;
        end
        r.value = q[31:0];
        return r;
    endfunction

    function automatic void apply_request(t_spline_req rq);
        if (rq.func == bsce_pkg::FUNC_POINT) begin
            if (rq.slot < NPTS) ctl_pts[rq.slot] = rq.wval;
        end else if (rq.func == bsce_pkg::FUNC_KNOT) begin
            if (rq.slot < KDEPTH) knots[rq.slot] = rq.wval[15:0];
        end else if (rq.func == bsce_pkg::FUNC_EVAL) begin
            expected.insert(expected.size(), curve_at(rq.param));
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // input side
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            apply_request(pending.pop_front());
            in_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        logic        nv;
        t_spline_req rq;
        if (i_rst_n && !(s_axis_tvalid && !in_taken)) begin
            if (in_taken) begin
                in_taken = 1'b0;
                in_gap   = pick_gap();
            end
            nv = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending.size() > 0) begin
                nv = 1'b1;
                rq = pending[0];
                s_axis_tdata <= {1'b0, rq.param, rq.wval, rq.slot};
                s_axis_tuser <= rq.func;
            end
            s_axis_tvalid <= nv;
        end
    end

    // output side
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_curve_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h sat=%b", m_axis_tdata, m_axis_tuser);
            end else begin
                e = expected.pop_front();
                n_checked++;
                if (e.sat) n_sat++;
                if (m_axis_tdata !== e.value || m_axis_tuser[0] !== e.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: value exp %h got %h, sat exp %b got %b",
                                 n_checked, e.value, m_axis_tdata, e.sat, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected.size());
            $display("bspline_curve_evaluator_core_tb: errors");
            $finish;
        end
    end

    task automatic queue_req(logic [1:0] f, logic [6:0] s, logic [31:0] v, logic [15:0] p);
        t_spline_req rq;
        rq.func  = f;
        rq.slot  = s;
        rq.wval  = v;
        rq.param = p;
        pending.insert(pending.size(), rq);
        items_sent++;
        if (f == bsce_pkg::FUNC_EVAL) n_queries++;
        else n_writes++;
    endtask

    task automatic wait_idle();
        while (pending.size() > 0 || expected.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(logic addr_sel, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {addr_sel, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr_sel == bsce_pkg::REG_DEGREE) cur_degree = data[2:0];
        else cur_count = data[6:0];
    endtask

    function automatic logic [31:0] rand_point(bit wide);
        if (wide) return $urandom();
        return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endfunction

    // kmode 0 sorted random, 1 clamped uniform, 2 arbitrary
    task automatic run_phase(int deg, int cnt, int nq, int kmode, bit wide);
        int          d, c, nk, r;
        logic [15:0] kv [$];
        logic [15:0] p;
        wait_idle();
        no_idle = ($urandom_range(0, 4) == 0);
        apb_write(bsce_pkg::REG_DEGREE, 32'(deg));
        apb_write(bsce_pkg::REG_COUNT, 32'(cnt));
        d  = (deg > NDEG) ? NDEG : deg;
        c  = (cnt > NPTS) ? NPTS : cnt;
        nk = (c == 0) ? 0 : c + d + 1;
        kv.delete();
        for (int k = 0; k < nk; k++) begin
            if (kmode == 1)
                kv.insert(kv.size(), (k <= d) ? 16'd0 : (k >= c) ? bsce_pkg::ONE_Q15
                          : 16'((32768 * (k - d)) / (c - d)));
            else if (kmode == 2)
                kv.insert(kv.size(), 16'($urandom_range(0, 65535)));
            else
                kv.insert(kv.size(), 16'($urandom_range(0, 32768)));
        end
        if (kmode == 0) kv.sort();
        for (int k = 0; k < nk; k++)
            queue_req(bsce_pkg::FUNC_KNOT, 7'(k), {16'($urandom_range(0, 65535)), kv[k]},
                      16'($urandom()));
        for (int k = 0; k < c; k++)
            queue_req(bsce_pkg::FUNC_POINT, 7'(k), rand_point(wide), 16'($urandom()));
        for (int k = 0; k < nq; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                queue_req(2'd3, 7'($urandom()), $urandom(), 16'($urandom()));
            else if (r < 8)
                queue_req(bsce_pkg::FUNC_POINT, 7'($urandom_range(NPTS, 127)), $urandom(),
                          16'($urandom()));
            else if (r < 12)
                queue_req(bsce_pkg::FUNC_KNOT, 7'($urandom_range(KDEPTH, 127)), $urandom(),
                          16'($urandom()));
            else if (r < 20 && c > 0)
                queue_req(bsce_pkg::FUNC_POINT, 7'($urandom_range(0, c - 1)),
                          rand_point(wide), 16'd0);
            r = $urandom_range(0, 7);
            if (r == 0) p = 16'd0;
            else if (r == 1) p = bsce_pkg::ONE_Q15;
            else if (r < 4 && nk > 0) begin
                p = kv[$urandom_range(0, nk - 1)];
                if (p > bsce_pkg::ONE_Q15) p = bsce_pkg::ONE_Q15;
            end else p = 16'($urandom_range(0, 32768));
            queue_req(bsce_pkg::FUNC_EVAL, 7'($urandom()), $urandom(), p);
        end
    endtask

    initial begin
        int dg, ct, rr;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_taken      = 1'b0;
        in_gap        = 0;
        out_stall     = 0;
        no_idle       = 1'b0;
        for (int k = 0; k < NPTS; k++) ctl_pts[k] = '0;
        for (int k = 0; k < KDEPTH; k++) knots[k] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset setting, clamped cubic, extreme points and odd items
        for (int k = 0; k < 8; k++)
            queue_req(bsce_pkg::FUNC_KNOT, 7'(k), (k < 4) ? 32'd0 : 32'h0000_8000, 16'd0);
        queue_req(bsce_pkg::FUNC_POINT, 7'd0, 32'h8000_0000, 16'd0);
        queue_req(bsce_pkg::FUNC_POINT, 7'd1, 32'h7fff_ffff, 16'hffff);
        queue_req(bsce_pkg::FUNC_POINT, 7'd2, 32'h0001_0000, 16'd0);
        queue_req(bsce_pkg::FUNC_POINT, 7'd3, 32'h7fff_ffff, 16'd0);
        queue_req(bsce_pkg::FUNC_EVAL, 7'd0, 32'd0, 16'd0);
        queue_req(bsce_pkg::FUNC_EVAL, 7'h7f, 32'hffff_ffff, 16'd16384);
        queue_req(bsce_pkg::FUNC_EVAL, 7'd0, 32'd0, bsce_pkg::ONE_Q15);
        queue_req(bsce_pkg::FUNC_EVAL, 7'd0, 32'd0, 16'h7fff);
        queue_req(2'd3, 7'h7f, 32'hffff_ffff, 16'hffff);
        queue_req(bsce_pkg::FUNC_POINT, 7'd64, 32'h1234_5678, 16'd0);
        queue_req(bsce_pkg::FUNC_KNOT, 7'd127, 32'hffff_ffff, 16'd0);
        queue_req(bsce_pkg::FUNC_EVAL, 7'd0, 32'd0, 16'd1);

        // register extremes and out-of-range settings
        run_phase(0, 4, 6, 0, 0);
        run_phase(1, 2, 6, 1, 1);
        run_phase(5, 6, 6, 1, 0);
        run_phase(7, 5, 4, 0, 0);
        run_phase(3, 0, 4, 0, 0);
        run_phase(1, 64, 3, 1, 1);
        run_phase(5, 127, 1, 1, 0);
        run_phase(2, 4, 8, 2, 1);

        while (items_sent < ITEM_TARGET) begin
            rr = $urandom_range(0, 99);
            ct = (rr < 70) ? $urandom_range(2, 6) : (rr < 95) ? $urandom_range(7, 16)
                 : $urandom_range(17, 32);
            rr = $urandom_range(0, 99);
            dg = (rr < 8) ? 0 : (rr < 92) ? $urandom_range(1, 5) : $urandom_range(6, 7);
            rr = $urandom_range(0, 99);
            run_phase(dg, ct, $urandom_range(5, 12), (rr < 45) ? 1 : (rr < 85) ? 0 : 2,
                      $urandom_range(0, 3) == 0);
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        $display("%0d requests (%0d queries, %0d writes), %0d results checked",
                 items_sent, n_queries, n_writes, n_checked);
        $display("%0d saturated results, %0d mismatches", n_sat, mismatches);
        if (mismatches == 0 && expected.size() == 0) begin
            $display("bspline_curve_evaluator_core_tb: clean");
        end else begin
            $display("bspline_curve_evaluator_core_tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
design/bsce_pkg.sv
design/bsce_ram.sv
design/bsce_div.sv
design/bsce_eval.sv
design/bspline_curve_evaluator_core.sv
dv/bspline_curve_evaluator_core_tb.sv
